// ===== sv/pbsq_pkg.sv =====
// Shared types and constants for the polyBLEP square-wave DAC sampler.
// Used by pbsq_lane and polyblep_square_dac_sampler_core; no dependencies.
package pbsq_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned DAC_W = 12;

   localparam logic [DATA_W-1:0] ONE_Q16 = 32'h0001_0000;
   localparam logic [DATA_W-1:0] INT_PART_MASK = 32'hFFFF_0000;
   localparam logic signed [DATA_W-1:0] DAC_OFFSET = 32'sd2048;
   localparam logic signed [DATA_W-1:0] DAC_MAX = 32'sd4095;

   typedef struct packed {
      logic done;
      logic [DATA_W-1:0] coef;
      logic [DATA_W-1:0] sq;
   } lane_res_type;

endpackage

// ===== sv/polyblep_square_dac_sampler_core.sv =====
// Square-wave sampler with two-sided polyBLEP edge correction and a 12-bit DAC code output.
// Each result is the previous corrected sample, so the output lags the input by one item.
// A sample without a level change goes from its transfer straight to the output state, which
// loads its result once the output register is free. At a level change, two lanes run in
// parallel. Each is a one-bit-per-cycle restoring divider, a sign-fix step and a shift-add
// squarer. The calculation, apply and output states then combine the coefficients, apply the
// earlier correction and load the output register; only then can the next transfer be taken.
// A new item is taken while the previous result still waits in the output register.
// Depends on pbsq_pkg and pbsq_lane.
module polyblep_square_dac_sampler_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_level,
   input  logic signed [31:0] req_phase,
   input  logic signed [31:0] req_increment,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [11:0]        rsp_dac_sample
);
   import pbsq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CALC,
      S_APPLY,
      S_OUT
   } core_state_type;

   localparam logic [1:0] POL_NONE = 2'd0;
   localparam logic [1:0] POL_NEG = 2'd1;
   localparam logic [1:0] POL_POS = 2'd2;

   core_state_type state_ff;
   logic [1:0] prev_pol_ff;
   logic [DATA_W-1:0] prev_phase_ff;
   logic [DATA_W-1:0] prev_sample_ff;
   logic [DATA_W-1:0] cur_ff;
   logic [DATA_W-1:0] blep_last_ff;
   logic [DATA_W-1:0] shaped_ff;
   logic lvl_ff;
   logic rsp_valid_ff;
   logic [DAC_W-1:0] dac_ff;

   logic accept;
   logic [1:0] pol_in;
   logic is_edge;
   logic [DATA_W-1:0] phase_u;
   logic [DATA_W-1:0] last_diff;
   logic [DATA_W-1:0] num_last;
   logic [DATA_W-1:0] num_this;
   logic lane_start;
   lane_res_type res_last;
   lane_res_type res_this;
   logic [DATA_W-1:0] blep_last_in;
   logic [DATA_W-1:0] shaped_in;
   logic signed [DATA_W-1:0] shifted;
   logic signed [DATA_W-1:0] dac_sum;
   logic [DAC_W-1:0] dac_in;
   logic out_load;
   logic rsp_valid_in;

   assign req_ready = (state_ff == S_IDLE);
   assign accept = req_valid && req_ready;
   assign pol_in = req_level ? POL_POS : POL_NEG;
   assign is_edge = (pol_in != prev_pol_ff);

   assign phase_u = $unsigned(req_phase);
   assign last_diff = (phase_u & INT_PART_MASK) - prev_phase_ff;
   assign num_last = {last_diff[15:0], 16'h0000};
   assign num_this = {phase_u[15:0], 16'h0000};
   assign lane_start = accept && is_edge;

   pbsq_lane u_lane_last (
      .clock (clock),
      .reset (reset),
      .start (lane_start),
      .num   (num_last),
      .den   ($unsigned(req_increment)),
      .res   (res_last)
   );

   pbsq_lane u_lane_this (
      .clock (clock),
      .reset (reset),
      .start (lane_start),
      .num   (num_this),
      .den   ($unsigned(req_increment)),
      .res   (res_this)
   );

   assign blep_last_in = {res_last.coef[DATA_W-2:0], 1'b0} - res_last.sq - ONE_Q16;
   assign shaped_in = '0 - res_this.sq - {res_this.coef[DATA_W-2:0], 1'b0};

   assign shifted = $signed(prev_sample_ff) >>> 6;
   assign dac_sum = shifted + DAC_OFFSET;
   always_comb begin
      if (dac_sum < 0) begin
         dac_in = '0;
      end else if (dac_sum > DAC_MAX) begin
         dac_in = DAC_MAX[DAC_W-1:0];
      end else begin
         dac_in = dac_sum[DAC_W-1:0];
      end
   end

   assign out_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         prev_pol_ff <= POL_NONE;
         prev_phase_ff <= '0;
         prev_sample_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  lvl_ff <= req_level;
                  prev_pol_ff <= pol_in;
                  prev_phase_ff <= phase_u;
                  if (is_edge) begin
                     state_ff <= S_CALC;
                  end else begin
                     cur_ff <= req_level ? ONE_Q16 : ('0 - ONE_Q16);
                     state_ff <= S_OUT;
                  end
               end
            end
            S_CALC: begin
               if (res_last.done) begin
                  blep_last_ff <= blep_last_in;
                  shaped_ff <= shaped_in;
                  state_ff <= S_APPLY;
               end
            end
            S_APPLY: begin
               prev_sample_ff <= lvl_ff ? (prev_sample_ff - blep_last_ff)
                                        : (prev_sample_ff + blep_last_ff);
               cur_ff <= lvl_ff ? shaped_ff : ('0 - shaped_ff);
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_load) begin
                  dac_ff <= dac_in;
                  prev_sample_ff <= cur_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_dac_sample = dac_ff;

`ifndef NO_ASSERTIONS
   a_lanes_in_step: assert property (@(posedge clock) disable iff (reset)
      res_last.done == res_this.done)
      else $error("The two coefficient lanes finished in different cycles.");

   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      res_last.done |-> state_ff == S_CALC)
      else $error("A lane finished outside the calculation state.");

   a_no_edge_fast: assert property (@(posedge clock) disable iff (reset)
      accept && !is_edge |=> state_ff == S_OUT)
      else $error("A sample without a level change did not go straight to output.");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_OUT))
      else $error("A result appeared without passing the output state.");
`endif

endmodule

// ===== sv/pbsq_lane.sv =====
// One coefficient lane: a bit-serial signed division followed by a bit-serial squaring in 16.16.
// Depends on pbsq_pkg for the data width and the result struct.
module pbsq_lane (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [31:0]          num,
   input  logic [31:0]          den,
   output pbsq_pkg::lane_res_type res
);
   import pbsq_pkg::*;

   typedef enum logic [1:0] {
      L_IDLE,
      L_DIV,
      L_FIX,
      L_MUL
   } lane_state_type;

   lane_state_type state_ff;
   logic [4:0] count_ff;
   logic [DATA_W-1:0] rem_ff;
   logic [DATA_W-1:0] shreg_ff;
   logic [DATA_W-1:0] dm_ff;
   logic [DATA_W-1:0] hi_ff;
   logic [DATA_W-1:0] coef_ff;
   logic neg_ff;
   logic dz_ff;
   logic done_ff;

   logic [DATA_W-1:0] nm_in;
   logic [DATA_W-1:0] dm_in;
   logic [DATA_W-1:0] trial;
   logic trial_ge;
   logic [DATA_W-1:0] coef_in;
   logic [DATA_W-1:0] mag_in;
   logic [DATA_W:0] acc_in;

   assign nm_in = num[DATA_W-1] ? (~num + 1'b1) : num;
   assign dm_in = den[DATA_W-1] ? (~den + 1'b1) : den;

   assign trial = {rem_ff[DATA_W-2:0], shreg_ff[DATA_W-1]};
   assign trial_ge = (trial >= dm_ff);

   assign coef_in = dz_ff ? '0 : (neg_ff ? (~shreg_ff + 1'b1) : shreg_ff);
   assign mag_in = coef_in[DATA_W-1] ? (~coef_in + 1'b1) : coef_in;

   assign acc_in = {1'b0, hi_ff} + (shreg_ff[0] ? {1'b0, dm_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            L_IDLE: begin
               if (start) begin
                  shreg_ff <= nm_in;
                  dm_ff <= dm_in;
                  rem_ff <= '0;
                  neg_ff <= num[DATA_W-1] ^ den[DATA_W-1];
                  dz_ff <= (dm_in == '0);
                  count_ff <= '0;
                  state_ff <= L_DIV;
               end
            end
            L_DIV: begin
               rem_ff <= trial_ge ? (trial - dm_ff) : trial;
               shreg_ff <= {shreg_ff[DATA_W-2:0], trial_ge};
               count_ff <= count_ff + 1'b1;
               if (count_ff == 5'd31) begin
                  state_ff <= L_FIX;
               end
            end
            L_FIX: begin
               coef_ff <= coef_in;
               dm_ff <= mag_in;
               shreg_ff <= mag_in;
               hi_ff <= '0;
               count_ff <= '0;
               state_ff <= L_MUL;
            end
            L_MUL: begin
               hi_ff <= acc_in[DATA_W:1];
               shreg_ff <= {acc_in[0], shreg_ff[DATA_W-1:1]};
               count_ff <= count_ff + 1'b1;
               if (count_ff == 5'd31) begin
                  done_ff <= 1'b1;
                  state_ff <= L_IDLE;
               end
            end
            default: begin
               state_ff <= L_IDLE;
            end
         endcase
      end
   end

   assign res.done = done_ff;
   assign res.coef = coef_ff;
   assign res.sq = {hi_ff[15:0], shreg_ff[DATA_W-1:16]};

endmodule
